[design/scfa_pkg.sv]
package scfa_pkg;

	localparam int unsigned FRAMES_PER_RESULT_DEF = 4;
	localparam int unsigned FRAME_LENGTH_DEF      = 5;

	localparam int unsigned DATA_W   = 8;
	localparam int unsigned VALUE_W  = 16;
	localparam int unsigned STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_READY    = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_SHORT    = 2'd2
	} status_t;

	typedef enum logic {
		KIND_BYTE  = 1'b0,
		KIND_SHORT = 1'b1
	} kind_t;

	typedef struct packed {
		logic    hit;
		status_t status;
	} res_t;

endpackage

[design/scfa_frame.sv]
module scfa_frame #(
	parameter int unsigned FRAMES_PER_RESULT = scfa_pkg::FRAMES_PER_RESULT_DEF,
	parameter int unsigned FRAME_LENGTH      = scfa_pkg::FRAME_LENGTH_DEF
) (
	input  logic                                                       clk,
	input  logic                                                       arst_n,
	input  logic                                                       en,
	input  logic                                                       kind,
	input  logic [scfa_pkg::DATA_W-1:0]                                data_byte,
	output scfa_pkg::res_t                                             res,
	output logic [scfa_pkg::VALUE_W+$clog2(FRAMES_PER_RESULT)-1:0]     sum
);
	import scfa_pkg::*;

	localparam int unsigned SUM_W  = VALUE_W + $clog2(FRAMES_PER_RESULT);
	localparam int unsigned POS_W  = $clog2(FRAME_LENGTH);
	localparam int unsigned GCNT_W = $clog2(FRAMES_PER_RESULT + 1);

	logic [POS_W-1:0]   pos_q, pos_nx;
	logic [DATA_W-1:0]  csum_q, csum_nx, csum_upd;
	logic [DATA_W-1:0]  chk_q, chk_nx, chk_upd;
	logic [VALUE_W-1:0] val_q, val_nx, val_upd;
	logic [GCNT_W-1:0]  gcnt_q, gcnt_nx;
	logic [SUM_W-1:0]   grp_q, grp_nx, grp_add;
	logic [DATA_W-1:0]  computed;
	logic               pos_last;

	always_comb begin
		pos_last = (pos_q == POS_W'(FRAME_LENGTH - 1));
		csum_upd = (pos_q == '0) ? csum_q : DATA_W'(csum_q + data_byte);
		chk_upd  = (pos_q == '0) ? data_byte : chk_q;
		if (pos_q == POS_W'(1)) begin
			val_upd = {data_byte, val_q[DATA_W-1:0]};
		end else if (pos_q == POS_W'(2)) begin
			val_upd = {val_q[VALUE_W-1:DATA_W], data_byte};
		end else begin
			val_upd = val_q;
		end
		computed = DATA_W'(~csum_upd + 1'b1);
		grp_add  = grp_q + SUM_W'(val_upd);

		pos_nx     = '0;
		csum_nx    = '0;
		chk_nx     = '0;
		val_nx     = '0;
		gcnt_nx    = '0;
		grp_nx     = '0;
		res.hit    = 1'b0;
		res.status = ST_READY;
		sum        = '0;

		if (kind == KIND_SHORT) begin
			res.hit    = 1'b1;
			res.status = ST_SHORT;
		end else if (!pos_last) begin
			pos_nx  = POS_W'(pos_q + POS_W'(1));
			csum_nx = csum_upd;
			chk_nx  = chk_upd;
			val_nx  = val_upd;
			gcnt_nx = gcnt_q;
			grp_nx  = grp_q;
		end else if (computed != chk_upd) begin
			res.hit    = 1'b1;
			res.status = ST_MISMATCH;
		end else if (gcnt_q == GCNT_W'(FRAMES_PER_RESULT - 1)) begin
			res.hit    = 1'b1;
			res.status = ST_READY;
			sum        = grp_add;
		end else begin
			gcnt_nx = GCNT_W'(gcnt_q + GCNT_W'(1));
			grp_nx  = grp_add;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			csum_q <= '0;
			chk_q  <= '0;
			val_q  <= '0;
			gcnt_q <= '0;
			grp_q  <= '0;
		end else if (en) begin
			pos_q  <= pos_nx;
			csum_q <= csum_nx;
			chk_q  <= chk_nx;
			val_q  <= val_nx;
			gcnt_q <= gcnt_nx;
			grp_q  <= grp_nx;
		end
	end

endmodule

[design/scfa_avg.sv]
module scfa_avg #(
	parameter int unsigned FRAMES_PER_RESULT = scfa_pkg::FRAMES_PER_RESULT_DEF
) (
	input  logic [scfa_pkg::VALUE_W+$clog2(FRAMES_PER_RESULT)-1:0] sum,
	output logic [scfa_pkg::VALUE_W-1:0]                           average
);
	import scfa_pkg::*;

	// exact floor division by a reciprocal: k = sum width + ceil(log2 n)
	localparam int unsigned SUM_W  = VALUE_W + $clog2(FRAMES_PER_RESULT);
	localparam int unsigned K      = SUM_W + $clog2(FRAMES_PER_RESULT);
	localparam int unsigned M_W    = K + 1;
	localparam int unsigned PROD_W = SUM_W + M_W;
	localparam longint unsigned RECIP_VAL =
		((64'd1 << K) + FRAMES_PER_RESULT - 1) / FRAMES_PER_RESULT;
	localparam logic [M_W-1:0] RECIP = M_W'(RECIP_VAL);

	logic [PROD_W-1:0] prod;

	always_comb begin
		prod    = PROD_W'(sum) * PROD_W'(RECIP);
		average = prod[K +: VALUE_W];
	end

endmodule

[design/sensor_frame_checksum_averager_core.sv]
// channel  signals                   payload
// -------  ------------------------  ----------------------------------
// in       in_valid / in_stall       kind, data_byte
// out      out_valid / out_stall     status, average
//
// one byte per cycle while out_stall is low; the byte that completes a result passes through the
// input register, frame result stage and output register before out_valid rises
// the group average is a constant reciprocal multiply ahead of the output register
// arst_n clears the frame position, checksum, group count and all valid bits
// out_stall backs up through the stages; in_stall only while all three hold data and out_stall is high
module sensor_frame_checksum_averager_core #(
	parameter int unsigned FRAMES_PER_RESULT = scfa_pkg::FRAMES_PER_RESULT_DEF,
	parameter int unsigned FRAME_LENGTH      = scfa_pkg::FRAME_LENGTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           kind,
	input  logic [scfa_pkg::DATA_W-1:0]    data_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [scfa_pkg::STATUS_W-1:0]  status,
	output logic [scfa_pkg::VALUE_W-1:0]   average
);
	import scfa_pkg::*;

	localparam int unsigned SUM_W = VALUE_W + $clog2(FRAMES_PER_RESULT);

	logic               v_s1, v_s2, out_valid_q;
	logic               kind_s1;
	logic [DATA_W-1:0]  byte_s1;
	status_t            status_s2, status_q;
	logic [SUM_W-1:0]   sum_s2, frame_sum;
	logic [VALUE_W-1:0] average_q, quot;
	res_t               frame_res;
	logic               rdy_out, rdy_s2, rdy_s1, s1_fire;

	assign rdy_out  = !out_valid_q || !out_stall;
	assign rdy_s2   = !v_s2 || rdy_out;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign s1_fire  = v_s1 && rdy_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			kind_s1 <= kind;
			byte_s1 <= data_byte;
		end
	end

	scfa_frame #(
		.FRAMES_PER_RESULT (FRAMES_PER_RESULT),
		.FRAME_LENGTH      (FRAME_LENGTH)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (s1_fire),
		.kind      (kind_s1),
		.data_byte (byte_s1),
		.res       (frame_res),
		.sum       (frame_sum)
	);

	// frame result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= s1_fire && frame_res.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && frame_res.hit) begin
			status_s2 <= frame_res.status;
			sum_s2    <= frame_sum;
		end
	end

	scfa_avg #(
		.FRAMES_PER_RESULT (FRAMES_PER_RESULT)
	) u_avg (
		.sum     (sum_s2),
		.average (quot)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_s2) begin
			status_q  <= status_s2;
			average_q <= quot;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign average   = average_q;

`ifndef SYNTHESIS
	a_err_zero_avg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_READY |-> average == '0)
		else $error("error status with nonzero average");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s2 && out_valid_q)
		else $error("input stalled with a free stage");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s2))
		else $error("result without a frame stage entry");

	a_s2_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s2) |-> $past(v_s1))
		else $error("frame stage filled without an input transfer");
`endif

endmodule
